[rtl/barometric_sensor_compensation_macros.svh]
// Assertion macros for the barometric compensation RTL.
`ifndef BAROMETRIC_SENSOR_COMPENSATION_MACROS_SVH
`define BAROMETRIC_SENSOR_COMPENSATION_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BSC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bsc check failed");

// Next-cycle implication, checked outside reset.
`define BSC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bsc check failed");

`endif

[rtl/bsc_pkg.sv]
// Types and constants for the barometric compensation pipeline.
`default_nettype none
package bsc_pkg;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_UPZ  = 2'd1;
  localparam logic [1:0] ST_DIV0 = 2'd2;

  localparam logic [7:0] REG_OSS   = 8'd0;
  localparam logic [7:0] REG_CAL_A = 8'd1;
  localparam logic [7:0] REG_CAL_B = 8'd2;
  localparam logic [7:0] REG_CAL_C = 8'd3;

  localparam logic [31:0] B6_OFFSET = 32'd4000;
  localparam logic [31:0] K_SQ      = 32'd3038;
  localparam logic [31:0] K_LIN     = 32'hFFFF_E343;
  localparam logic [31:0] K_OFFSET  = 32'd3791;
  localparam logic [31:0] P_SCALE   = 32'd50000;
  localparam logic [31:0] B4_BIAS   = 32'd32768;

  typedef struct packed {
    logic [18:0] up;
    logic [31:0] x1;
    logic        neg;
    logic [1:0]  status;
  } div1_pl_t;

  typedef struct packed {
    logic [15:0] temp;
    logic        dbl;
    logic [1:0]  status;
  } div2_pl_t;

  function automatic logic [31:0] asr32(input logic [31:0] v, input int unsigned s);
    asr32 = 32'($signed(v) >>> s);
  endfunction

endpackage
`default_nettype wire

[rtl/bsc_udiv.sv]
// Pipelined restoring unsigned divider, one quotient bit per stage.
`default_nettype none
module bsc_udiv #(
  parameter int W  = 32,
  parameter int PW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          in_vld,
  input  wire logic [W-1:0]  dividend,
  input  wire logic [W-1:0]  divisor,
  input  wire logic [PW-1:0] in_pl,
  output logic               out_vld,
  output logic [W-1:0]       quotient,
  output logic [PW-1:0]      out_pl
);

  logic [W-1:0]  rem [W];
  logic [W-1:0]  dvd [W];
  logic [W-1:0]  dvs [W];
  logic [PW-1:0] pl  [W];
  logic          vld [W];

  for (genvar k = 0; k < W; k++) begin : g_stage
    logic [W-1:0]  prem, pdvd, pdvs;
    logic [PW-1:0] ppl;
    logic          pvld;
    logic [W:0]    trial, diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign prem = '0;
      assign pdvd = dividend;
      assign pdvs = divisor;
      assign ppl  = in_pl;
      assign pvld = in_vld;
    end else begin : g_next
      assign prem = rem[k-1];
      assign pdvd = dvd[k-1];
      assign pdvs = dvs[k-1];
      assign ppl  = pl[k-1];
      assign pvld = vld[k-1];
    end

    assign trial = {prem, pdvd[W-1]};
    assign ge    = trial >= {1'b0, pdvs};
    assign diff  = trial - {1'b0, pdvs};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= pvld;
      end
      if (en) begin
        rem[k] <= ge ? diff[W-1:0] : trial[W-1:0];
        dvd[k] <= {pdvd[W-2:0], ge};
        dvs[k] <= pdvs;
        pl[k]  <= ppl;
      end
    end
  end

  assign out_vld  = vld[W-1];
  assign quotient = dvd[W-1];
  assign out_pl   = pl[W-1];

endmodule
`default_nettype wire

[rtl/barometric_sensor_compensation.sv]
// Top level of the barometric compensation pipeline.
`default_nettype none
`include "barometric_sensor_compensation_macros.svh"
// Fully pipelined: one sample pair is accepted every cycle unless a result waits at the
// output, and passes through two front stages, two 32-stage dividers of one quotient bit
// each, six pressure stages and three correction stages. The whole pipeline holds while
// a result waits at the output.
// Calibration writes take effect at once and must be made while the pipeline is empty.
module barometric_sensor_compensation (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // raw_temperature[15:0], raw_pressure[34:16], zeros
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [55:0]      m_tdata,   // status[1:0], temperature_tenths[17:2],
                                      // pressure_pa[49:18], zeros
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  logic        en;
  logic [1:0]  oss;
  logic [63:0] cal_a, cal_b;
  logic [31:0] cal_c;
  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      oss   <= '0;
      cal_a <= '0;
      cal_b <= '0;
      cal_c <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        bsc_pkg::REG_OSS:   oss   <= cfg_data[1:0];
        bsc_pkg::REG_CAL_A: cal_a <= cfg_data;
        bsc_pkg::REG_CAL_B: cal_b <= cfg_data;
        bsc_pkg::REG_CAL_C: cal_c <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  assign ac1 = {{16{cal_a[63]}}, cal_a[63:48]};
  assign ac2 = {{16{cal_a[47]}}, cal_a[47:32]};
  assign ac3 = {{16{cal_a[31]}}, cal_a[31:16]};
  assign ac4 = {16'd0, cal_a[15:0]};
  assign ac5 = {16'd0, cal_b[63:48]};
  assign ac6 = {16'd0, cal_b[47:32]};
  assign b1  = {{16{cal_b[31]}}, cal_b[31:16]};
  assign b2  = {{16{cal_b[15]}}, cal_b[15:0]};
  assign mc  = {{16{cal_c[31]}}, cal_c[31:16]};
  assign md  = {{16{cal_c[15]}}, cal_c[15:0]};

  logic o_vld;
  assign en       = !o_vld || m_tready;
  assign s_tready = en;

  // Stage A: temperature product.
  logic        a_vld, a_upz;
  logic [18:0] a_up;
  logic [31:0] a_prod;
  // Stage B: temperature divisor.
  logic        b_vld, b_upz;
  logic [18:0] b_up;
  logic [31:0] b_x1, b_den;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
    end else if (en) begin
      a_vld <= s_tvalid;
      b_vld <= a_vld;
    end
    if (en) begin
      a_up   <= s_tdata[34:16];
      a_upz  <= s_tdata[34:16] == 19'd0;
      a_prod <= 32'((32'(s_tdata[15:0]) - ac6) * ac5);
      b_up   <= a_up;
      b_upz  <= a_upz;
      b_x1   <= bsc_pkg::asr32(a_prod, 15);
      b_den  <= bsc_pkg::asr32(a_prod, 15) + md;
    end
  end

  // Signed division is done on magnitudes with the sign restored afterwards.
  logic [31:0]       num, mag_n, mag_d;
  bsc_pkg::div1_pl_t d1_in, d1_out;
  logic              d1_vld;
  logic [31:0]       d1_q;

  assign num   = mc << 11;
  assign mag_n = num[31] ? 32'(-num) : num;
  assign mag_d = b_den[31] ? 32'(-b_den) : b_den;

  always_comb begin
    d1_in.up  = b_up;
    d1_in.x1  = b_x1;
    d1_in.neg = num[31] ^ b_den[31];
    if (b_upz) begin
      d1_in.status = bsc_pkg::ST_UPZ;
    end else if (b_den == 32'd0) begin
      d1_in.status = bsc_pkg::ST_DIV0;
    end else begin
      d1_in.status = bsc_pkg::ST_OK;
    end
  end

  bsc_udiv #(.W(32), .PW($bits(bsc_pkg::div1_pl_t))) u_div_t (
    .clk(clk), .rst(rst), .en(en), .in_vld(b_vld),
    .dividend(mag_n), .divisor(mag_d), .in_pl(d1_in),
    .out_vld(d1_vld), .quotient(d1_q), .out_pl(d1_out)
  );

  logic [31:0] x2t, b5;
  assign x2t = d1_out.neg ? 32'(-d1_q) : d1_q;
  assign b5  = d1_out.x1 + x2t;

  logic        d_vld, p1_vld, p2_vld, p3_vld, p4_vld, p5_vld;
  logic [31:0] d_b6;
  logic [15:0] d_temp, p1_temp, p2_temp, p3_temp, p4_temp, p5_temp;
  logic [18:0] d_up, p1_up, p2_up, p3_up, p4_up;
  logic [1:0]  d_st, p1_st, p2_st, p3_st, p4_st, p5_st;
  logic [31:0] p1_sqp, p1_a2, p1_a3, p2_b2, p2_b1, p2_a2, p2_a3;
  logic [31:0] p3_b3, p3_v, p4_b4p, p4_b3, p5_b4, p5_b7;
  logic [31:0] sq, x3a, x3b;

  assign sq  = bsc_pkg::asr32(p1_sqp, 12);
  assign x3a = bsc_pkg::asr32(p2_b2, 11) + bsc_pkg::asr32(p2_a2, 11);
  assign x3b = bsc_pkg::asr32(bsc_pkg::asr32(p2_a3, 13) + bsc_pkg::asr32(p2_b1, 16)
                              + 32'd2, 2);

  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld  <= 1'b0;
      p1_vld <= 1'b0;
      p2_vld <= 1'b0;
      p3_vld <= 1'b0;
      p4_vld <= 1'b0;
      p5_vld <= 1'b0;
    end else if (en) begin
      d_vld  <= d1_vld;
      p1_vld <= d_vld;
      p2_vld <= p1_vld;
      p3_vld <= p2_vld;
      p4_vld <= p3_vld;
      p5_vld <= p4_vld;
    end
    if (en) begin
      d_b6    <= b5 - bsc_pkg::B6_OFFSET;
      d_temp  <= 16'(bsc_pkg::asr32(b5 + 32'd8, 4));
      d_up    <= d1_out.up;
      d_st    <= d1_out.status;
      p1_sqp  <= 32'(d_b6 * d_b6);
      p1_a2   <= 32'(ac2 * d_b6);
      p1_a3   <= 32'(ac3 * d_b6);
      p1_temp <= d_temp;
      p1_up   <= d_up;
      p1_st   <= d_st;
      p2_b2   <= 32'(b2 * sq);
      p2_b1   <= 32'(b1 * sq);
      p2_a2   <= p1_a2;
      p2_a3   <= p1_a3;
      p2_temp <= p1_temp;
      p2_up   <= p1_up;
      p2_st   <= p1_st;
      p3_b3   <= bsc_pkg::asr32((((ac1 << 2) + x3a) << oss) + 32'd2, 2);
      p3_v    <= x3b + bsc_pkg::B4_BIAS;
      p3_temp <= p2_temp;
      p3_up   <= p2_up;
      p3_st   <= p2_st;
      p4_b4p  <= 32'(ac4 * p3_v);
      p4_b3   <= p3_b3;
      p4_temp <= p3_temp;
      p4_up   <= p3_up;
      p4_st   <= p3_st;
      p5_b4   <= p4_b4p >> 15;
      p5_b7   <= 32'((32'(p4_up) - p4_b3) * (bsc_pkg::P_SCALE >> oss));
      p5_temp <= p4_temp;
      p5_st   <= p4_st;
    end
  end

  bsc_pkg::div2_pl_t d2_in, d2_out;
  logic              d2_vld;
  logic [31:0]       d2_num, d2_q;

  always_comb begin
    d2_in.temp = p5_temp;
    d2_in.dbl  = p5_b7[31];
    d2_num     = p5_b7[31] ? p5_b7 : (p5_b7 << 1);
    if (p5_st == bsc_pkg::ST_OK && p5_b4 == 32'd0) begin
      d2_in.status = bsc_pkg::ST_DIV0;
    end else begin
      d2_in.status = p5_st;
    end
  end

  bsc_udiv #(.W(32), .PW($bits(bsc_pkg::div2_pl_t))) u_div_p (
    .clk(clk), .rst(rst), .en(en), .in_vld(p5_vld),
    .dividend(d2_num), .divisor(p5_b4), .in_pl(d2_in),
    .out_vld(d2_vld), .quotient(d2_q), .out_pl(d2_out)
  );

  logic [31:0] p_raw, ps;
  assign p_raw = d2_out.dbl ? (d2_q << 1) : d2_q;
  assign ps    = bsc_pkg::asr32(p_raw, 8);

  logic        q1_vld, q2_vld;
  logic [31:0] q1_m, q1_n, q1_p, q2_x, q2_n, q2_p;
  logic [15:0] q1_temp, q2_temp;
  logic [1:0]  q1_st, q2_st;
  logic [31:0] cx1, cx2, p_fin;
  logic [1:0]  o_st;
  logic [15:0] o_temp;
  logic [31:0] o_p;

  assign cx1   = bsc_pkg::asr32(q2_x, 16);
  assign cx2   = bsc_pkg::asr32(q2_n, 16);
  assign p_fin = q2_p + bsc_pkg::asr32(cx1 + cx2 + bsc_pkg::K_OFFSET, 4);

  always_ff @(posedge clk) begin
    if (rst) begin
      q1_vld <= 1'b0;
      q2_vld <= 1'b0;
      o_vld  <= 1'b0;
    end else if (en) begin
      q1_vld <= d2_vld;
      q2_vld <= q1_vld;
      o_vld  <= q2_vld;
    end
    if (en) begin
      q1_m    <= 32'(ps * ps);
      q1_n    <= 32'(bsc_pkg::K_LIN * p_raw);
      q1_p    <= p_raw;
      q1_temp <= d2_out.temp;
      q1_st   <= d2_out.status;
      q2_x    <= 32'(q1_m * bsc_pkg::K_SQ);
      q2_n    <= q1_n;
      q2_p    <= q1_p;
      q2_temp <= q1_temp;
      q2_st   <= q1_st;
      o_st    <= q2_st;
      // A faulted transaction reports zero in both result fields.
      o_temp  <= (q2_st == bsc_pkg::ST_OK) ? q2_temp : 16'd0;
      o_p     <= (q2_st == bsc_pkg::ST_OK) ? p_fin : 32'd0;
    end
  end

  assign m_tvalid = o_vld;
  assign m_tdata  = {6'd0, o_p, o_temp, o_st};

  `BSC_ASSERT_NOW(a_status_code, m_tvalid, m_tdata[1:0] != 2'd3)
  `BSC_ASSERT_NOW(a_fault_zero, m_tvalid && m_tdata[1:0] != bsc_pkg::ST_OK,
                  m_tdata[49:2] == 48'd0)
  `BSC_ASSERT_NEXT(a_upz_flag, s_tvalid && s_tready && s_tdata[34:16] == 19'd0,
                   a_vld && a_upz)

endmodule
`default_nettype wire

[test/barometric_sensor_compensation_tb.sv]
// Self-checking bench for the barometric compensation pipeline: directed table, then random.
`timescale 1ns / 100ps
`default_nettype none
module barometric_sensor_compensation_tb;

  localparam int LATENCY     = 80;
  localparam int CYCLE_LIMIT = 400000;
  localparam int N_RANDOM    = 1750;
  localparam logic [7:0] REG_UNUSED = 8'd4;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] temp;
    logic [31:0] press;
  } reading_t;

  typedef struct {
    logic [15:0] ut;
    logic [18:0] up;
    bit          fixed;
    reading_t    want;
  } sample_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [39:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [7:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  logic [1:0]  oss;
  logic [63:0] cal_a, cal_b;
  logic [31:0] cal_c;

  reading_t pending_readings[$];
  int errors = 0;
  int n_sent = 0;
  int n_got = 0;
  int n_fault = 0;
  int cycles = 0;
  bit hold_off = 1'b0;

  barometric_sensor_compensation dut (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic [31:0] sext16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] shr_s(input logic [31:0] v, input int s);
    return 32'($signed(v) >>> s);
  endfunction

  function automatic logic [31:0] quot_trunc(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] ma, mb, q;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    q = ma / mb;
    return (a[31] != b[31]) ? -q : q;
  endfunction

  // Integer compensation, 32-bit wrap throughout.
  function automatic reading_t compensate(input logic [15:0] ut_in, input logic [18:0] up_in);
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    logic [31:0] ut, up, x1, x2, x3, b3, b4, b5, b6, b7, p, sq, den;
    reading_t r;
    r = '0;
    ut = {16'd0, ut_in};
    up = {13'd0, up_in};
    ac1 = sext16(cal_a[63:48]); ac2 = sext16(cal_a[47:32]);
    ac3 = sext16(cal_a[31:16]); ac4 = {16'd0, cal_a[15:0]};
    ac5 = {16'd0, cal_b[63:48]}; ac6 = {16'd0, cal_b[47:32]};
    b1 = sext16(cal_b[31:16]); b2 = sext16(cal_b[15:0]);
    mc = sext16(cal_c[31:16]); md = sext16(cal_c[15:0]);
    if (up == 0) begin
      r.status = bsc_pkg::ST_UPZ;
      return r;
    end
    x1 = shr_s((ut - ac6) * ac5, 15);
    den = x1 + md;
    if (den == 0) begin
      r.status = bsc_pkg::ST_DIV0;
      return r;
    end
    x2 = quot_trunc(mc << 11, den);
    b5 = x1 + x2;
    b6 = b5 - 32'd4000;
    sq = shr_s(b6 * b6, 12);
    x1 = shr_s(b2 * sq, 11);
    x2 = shr_s(ac2 * b6, 11);
    x3 = x1 + x2;
    b3 = shr_s(((ac1 * 4 + x3) << oss) + 2, 2);
    x1 = shr_s(ac3 * b6, 13);
    x2 = shr_s(b1 * sq, 16);
    x3 = shr_s(x1 + x2 + 2, 2);
    b4 = (ac4 * (x3 + 32'd32768)) >> 15;
    if (b4 == 0) begin
      r.status = bsc_pkg::ST_DIV0;
      return r;
    end
    b7 = (up - b3) * (32'd50000 >> oss);
    if (!b7[31]) p = (b7 << 1) / b4;
    else p = (b7 / b4) << 1;
    x1 = shr_s(p, 8) * shr_s(p, 8);
    x1 = shr_s(x1 * 32'd3038, 16);
    x2 = shr_s(32'hFFFF_E343 * p, 16);
    p = p + shr_s(x1 + x2 + 32'd3791, 4);
    r.status = bsc_pkg::ST_OK;
    r.temp = 16'(shr_s(b5 + 8, 4));
    r.press = p;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("Mismatch on result %0d: %s got %0h, expected %0h", n_got, what, got, want);
    errors++;
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      bsc_pkg::REG_OSS:   oss = value[1:0];
      bsc_pkg::REG_CAL_A: cal_a = value;
      bsc_pkg::REG_CAL_B: cal_b = value;
      bsc_pkg::REG_CAL_C: cal_c = value[31:0];
      default: ;
    endcase
  endtask

  task automatic send_sample(input logic [15:0] ut, input logic [18:0] up,
                             input bit fixed, input reading_t want, input bit gaps);
    int gap;
    reading_t r;
    gap = gaps ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    r = fixed ? want : compensate(ut, up);
    pending_readings.push_back(r);
    if (r.status != bsc_pkg::ST_OK) n_fault++;
    s_tvalid <= 1'b1;
    s_tdata <= {5'd0, up, ut};
    do @(posedge clk); while (!s_tready);
    n_sent++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  // Receiver: random stalls per transaction, plus one long hold-off.
  always @(posedge clk) begin
    reading_t got, want;
    if (m_tvalid && m_tready) begin
      got.status = m_tdata[1:0];
      got.temp = m_tdata[17:2];
      got.press = m_tdata[49:18];
      if (pending_readings.size() == 0) begin
        report_mismatch("unexpected transaction", m_tdata[31:0], 32'd0);
      end else begin
        want = pending_readings.pop_front();
        if (got.status != want.status)
          report_mismatch("status", 32'(got.status), 32'(want.status));
        if (got.temp != want.temp)
          report_mismatch("temperature", 32'(got.temp), 32'(want.temp));
        if (got.press != want.press) report_mismatch("pressure", got.press, want.press);
        if (m_tdata[55:50] != 6'd0) report_mismatch("padding", 32'(m_tdata[55:50]), 32'd0);
      end
      n_got++;
    end
  end

  initial begin
    int wait_n;
    @(negedge rst);
    forever begin
      if (hold_off) begin
        m_tready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      wait_n = (n_got % 400 < 100) ? 0 : $urandom_range(0, 8);
      if (wait_n > 0) begin
        m_tready <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // Typical calibration set and the directed rows.
  localparam logic [63:0] TYP_A = {16'sd408, -16'sd72, -16'sd14383, 16'd32741};
  localparam logic [63:0] TYP_B = {16'd32757, 16'd23153, 16'sd6190, 16'sd4};
  localparam logic [31:0] TYP_C = {-16'sd8711, 16'sd2868};

  sample_row_t table_rows[$];

  task automatic add_row(input logic [15:0] ut, input logic [18:0] up,
                         input bit fixed, input logic [1:0] st);
    sample_row_t row;
    row.ut = ut; row.up = up; row.fixed = fixed;
    row.want = '0;
    row.want.status = st;
    table_rows.push_back(row);
  endtask

  initial begin
    logic [63:0] v;
    oss = 0; cal_a = 0; cal_b = 0; cal_c = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // After reset all coefficients are zero: any nonzero pressure divides by zero.
    add_row(16'd27898, 19'd23843, 1, bsc_pkg::ST_DIV0);
    add_row(16'hFFFF, 19'h7FFFF, 1, bsc_pkg::ST_DIV0);
    add_row(16'd100, 19'd0, 1, bsc_pkg::ST_UPZ);
    foreach (table_rows[i])
      send_sample(table_rows[i].ut, table_rows[i].up, 1, table_rows[i].want, 0);
    drain();

    for (int k = 0; k < 4; k++) begin
      write_reg(bsc_pkg::REG_OSS, 64'(k));
      write_reg(bsc_pkg::REG_CAL_A, TYP_A);
      write_reg(bsc_pkg::REG_CAL_B, TYP_B);
      write_reg(bsc_pkg::REG_CAL_C, 64'(TYP_C));
      table_rows.delete();
      add_row(16'd27898, 19'd23843 << k, 0, bsc_pkg::ST_OK);
      add_row(16'd0, 19'd1, 0, bsc_pkg::ST_OK);
      add_row(16'hFFFF, 19'h7FFFF, 0, bsc_pkg::ST_OK);
      add_row(16'h8000, 19'h40000, 0, bsc_pkg::ST_OK);
      add_row(16'hFFFF, 19'd0, 1, bsc_pkg::ST_UPZ);
      foreach (table_rows[i])
        send_sample(table_rows[i].ut, table_rows[i].up, table_rows[i].fixed,
                    table_rows[i].want, 1);
      drain();
    end
    // Temperature divisor fault: ac5 zero makes X1 zero, md zero.
    write_reg(bsc_pkg::REG_CAL_B, 64'h0000_1234_0000_0000);
    write_reg(bsc_pkg::REG_CAL_C, 64'h7FFF_0000);
    send_sample(16'd500, 19'd7, 0, '0, 0);
    drain();
    // Extreme register contents, including index beyond the register list.
    write_reg(REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(bsc_pkg::REG_CAL_A, '1);
    write_reg(bsc_pkg::REG_CAL_B, '1);
    write_reg(bsc_pkg::REG_CAL_C, 64'h8000_8000);
    send_sample(16'hFFFF, 19'h7FFFF, 0, '0, 0);
    send_sample(16'h0000, 19'h00001, 0, '0, 0);
    drain();

    // Random part in phases: typical or random calibration, with one long stall.
    for (int ph = 0; ph < 14; ph++) begin
      write_reg(bsc_pkg::REG_OSS, 64'($urandom_range(0, 3)));
      if (ph % 3 == 0) begin
        write_reg(bsc_pkg::REG_CAL_A, {$urandom(), $urandom()});
        write_reg(bsc_pkg::REG_CAL_B, {$urandom(), $urandom()});
        write_reg(bsc_pkg::REG_CAL_C, 64'($urandom()));
      end else begin
        v = TYP_A;
        v[15:0] = 16'(30000 + $urandom_range(0, 5000));
        write_reg(bsc_pkg::REG_CAL_A, v);
        write_reg(bsc_pkg::REG_CAL_B, TYP_B ^ {48'd0, 16'($urandom_range(0, 15))});
        write_reg(bsc_pkg::REG_CAL_C, 64'(TYP_C));
      end
      if (ph == 5) hold_off = 1'b1;
      for (int i = 0; i < N_RANDOM / 14; i++) begin
        logic [15:0] ut;
        logic [18:0] up;
        ut = (i % 4 == 0) ? 16'($urandom()) : 16'(25000 + $urandom_range(0, 6000));
        up = (i % 4 == 1) ? 19'($urandom()) :
             (i % 50 == 7) ? 19'd0 : 19'((20000 + $urandom_range(0, 30000)) << oss);
        send_sample(ut, up, 0, '0, ph != 5 || i > 400);
      end
      drain();
    end

    $display("Sent %0d samples and checked %0d results, %0d of them fault statuses,",
             n_sent, n_got, n_fault);
    $display("over all oversampling settings and typical, random and extreme calibrations.");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
